// File: src/bgqg_pkg.sv
`timescale 1ns / 1ps

package bgqg_pkg;

    localparam int GLYPH_COLUMNS = 5;
    localparam int GLYPH_ROWS    = 7;
    localparam int GLYPH_BITS    = GLYPH_COLUMNS * GLYPH_ROWS;
    localparam int COORD_W       = 17;
    localparam int SCALE_W       = 6;
    localparam int CURSOR_W      = 16;
    localparam int COL_W         = 3;

    localparam logic [7:0] FONT_SIZE_RESET   = 8'd16;
    localparam logic [7:0] FONT_SIZE_DEFAULT = 8'd16;
    localparam logic [7:0] CASE_OFFSET       = 8'd32;
    localparam logic [7:0] CHR_SPACE         = 8'h20;
    localparam logic [7:0] CHR_CR            = 8'h0D;
    localparam logic [7:0] CHR_LF            = 8'h0A;
    localparam logic [7:0] CHR_TAB           = 8'h09;

    // reciprocal constants: n/7 = (n*293)>>11 and n*4/5 = (n*13108)>>14 for n < 256
    localparam logic [11:0] RECIP_SEVEN      = 12'd293;
    localparam int          RECIP_SEVEN_SH   = 11;
    localparam logic [13:0] RECIP_ASCENT     = 14'd13108;
    localparam int          RECIP_ASCENT_SH  = 14;

    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic blank;
        logic cur_lit;
        logic rest_zero;
        logic out_free;
    } t_dp_status;

    function automatic logic is_blank(input logic [7:0] code);
        return (code inside {CHR_SPACE, CHR_CR, CHR_LF, CHR_TAB});
    endfunction

    // row 0 sits in the top bits, leftmost column first
    function automatic logic [GLYPH_BITS-1:0] glyph_rows(input logic [7:0] code);
        logic [7:0] c;
        logic [GLYPH_BITS-1:0] g;
        c = code;
        if (code inside {["a":"z"]}) begin
            c = code - CASE_OFFSET;
        end
        case (c)
            "A":  g = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            "B":  g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
            "C":  g = {5'h0F, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h0F};
            "D":  g = {5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E};
            "E":  g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
            "F":  g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
            "G":  g = {5'h0F, 5'h10, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
            "H":  g = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
            "I":  g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h1F};
            "J":  g = {5'h07, 5'h02, 5'h02, 5'h02, 5'h12, 5'h12, 5'h0C};
            "K":  g = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
            "L":  g = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
            "M":  g = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
            "N":  g = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
            "O":  g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            "P":  g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
            "Q":  g = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
            "R":  g = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
            "S":  g = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
            "T":  g = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
            "U":  g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
            "V":  g = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
            "W":  g = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h15, 5'h0A};
            "X":  g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
            "Y":  g = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
            "Z":  g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
            "0":  g = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
            "1":  g = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
            "2":  g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
            "3":  g = {5'h1E, 5'h01, 5'h01, 5'h0E, 5'h01, 5'h01, 5'h1E};
            "4":  g = {5'h12, 5'h12, 5'h12, 5'h1F, 5'h02, 5'h02, 5'h02};
            "5":  g = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E};
            "6":  g = {5'h0E, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
            "7":  g = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
            "8":  g = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
            "9":  g = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h0E};
            ".":  g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C};
            ",":  g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C, 5'h08};
            ":":  g = {5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h00};
            ";":  g = {5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h08};
            "-":  g = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
            "_":  g = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h1F};
            "/":  g = {5'h01, 5'h02, 5'h02, 5'h04, 5'h08, 5'h08, 5'h10};
            "\\": g = {5'h10, 5'h08, 5'h08, 5'h04, 5'h02, 5'h02, 5'h01};
            "(":  g = {5'h02, 5'h04, 5'h08, 5'h08, 5'h08, 5'h04, 5'h02};
            ")":  g = {5'h08, 5'h04, 5'h02, 5'h02, 5'h02, 5'h04, 5'h08};
            "[":  g = {5'h0E, 5'h08, 5'h08, 5'h08, 5'h08, 5'h08, 5'h0E};
            "]":  g = {5'h0E, 5'h02, 5'h02, 5'h02, 5'h02, 5'h02, 5'h0E};
            "+":  g = {5'h00, 5'h04, 5'h04, 5'h1F, 5'h04, 5'h04, 5'h00};
            "=":  g = {5'h00, 5'h00, 5'h1F, 5'h00, 5'h1F, 5'h00, 5'h00};
            "!":  g = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
            "?":  g = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
            // missing glyph
            default: g = {5'h1F, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
        endcase
        return g;
    endfunction

endpackage

// File: src/bgqg_ctrl.sv
`timescale 1ns / 1ps

module bgqg_ctrl
    import bgqg_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_in_stall
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    // blank codes only move the cursor
                    if (!i_status.blank) begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // an unlit pixel always moves on, a lit one waits for the output slot
                o_cmd.step = !i_status.cur_lit || i_status.out_free;
                o_cmd.emit = i_status.cur_lit && i_status.out_free;
                if (o_cmd.step && i_status.rest_zero) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> (r_state == S_IDLE))
        else $error("load issued outside idle");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && o_cmd.step && i_status.rest_zero) |=> !o_in_stall)
        else $error("scan did not return to idle after last pixel");

    a_blank_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && i_status.blank) |=> (r_state == S_IDLE))
        else $error("blank code started a scan");

endmodule

// File: src/bgqg_datapath.sv
`timescale 1ns / 1ps

module bgqg_datapath
    import bgqg_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_status                 o_status,
    input  logic                       i_cfg_valid,
    input  logic [7:0]                 i_cfg_data,
    input  logic [7:0]                 i_char_code,
    input  logic                       i_string_start,
    input  logic signed [15:0]         i_origin_x,
    input  logic signed [15:0]         i_origin_y,
    input  logic                       i_out_stall,
    output logic                       o_out_valid,
    output logic signed [COORD_W-1:0]  o_quad_left,
    output logic signed [COORD_W-1:0]  o_quad_top,
    output logic signed [COORD_W-1:0]  o_quad_right,
    output logic signed [COORD_W-1:0]  o_quad_bottom,
    output logic                       o_last_quad
);

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(GLYPH_COLUMNS - 1);

    logic [7:0]            r_font_size;
    logic [GLYPH_BITS-1:0] r_glyph;
    logic [COL_W-1:0]      r_col;
    logic [COORD_W-1:0]    r_x;
    logic [COORD_W-1:0]    r_y;
    logic [COORD_W-1:0]    r_base_x;
    logic [SCALE_W-1:0]    r_scale;
    logic [CURSOR_W-1:0]   r_cursor;
    logic                  r_out_valid;
    logic [COORD_W-1:0]    r_out_left;
    logic [COORD_W-1:0]    r_out_top;
    logic [COORD_W-1:0]    r_out_right;
    logic [COORD_W-1:0]    r_out_bottom;
    logic                  r_out_last;

    logic [7:0]            size;
    logic [19:0]           scale_prod;
    logic [SCALE_W-1:0]    scale_raw;
    logic [SCALE_W-1:0]    scale;
    logic [21:0]           ascent_prod;
    logic [7:0]            ascent;
    logic [7:0]            advance;
    logic [CURSOR_W-1:0]   cursor_base;
    logic [COORD_W-1:0]    base_x;
    logic [COORD_W-1:0]    top;
    logic [COORD_W-1:0]    scale17;
    logic                  blank;

    always_comb begin
        size        = (r_font_size == 8'd0) ? FONT_SIZE_DEFAULT : r_font_size;
        scale_prod  = 20'(size) * 20'(RECIP_SEVEN);
        scale_raw   = scale_prod[RECIP_SEVEN_SH +: SCALE_W];
        scale       = (scale_raw == '0) ? SCALE_W'(1) : scale_raw;
        ascent_prod = 22'(size) * 22'(RECIP_ASCENT);
        ascent      = ascent_prod[RECIP_ASCENT_SH +: 8];
        blank       = is_blank(i_char_code);
        // space advance is half the glyph advance of six columns
        advance     = blank ? (8'(scale) * 8'd3) : (8'(scale) * 8'd6);
        cursor_base = i_string_start ? '0 : r_cursor;
        base_x      = {i_origin_x[15], i_origin_x} + {1'b0, cursor_base};
        top         = {i_origin_y[15], i_origin_y} - COORD_W'(ascent);
        scale17     = COORD_W'(r_scale);
    end

    assign o_status.blank     = blank;
    assign o_status.cur_lit   = r_glyph[GLYPH_BITS-1];
    assign o_status.rest_zero = (r_glyph[GLYPH_BITS-2:0] == '0);
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_font_size <= FONT_SIZE_RESET;
            r_cursor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_font_size <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_cursor <= cursor_base + CURSOR_W'(advance);
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_glyph  <= glyph_rows(i_char_code);
            r_col    <= '0;
            r_base_x <= base_x;
            r_x      <= base_x;
            r_y      <= top;
            r_scale  <= scale;
        end else if (i_cmd.step) begin
            r_glyph <= {r_glyph[GLYPH_BITS-2:0], 1'b0};
            if (r_col == COL_LAST) begin
                r_col <= '0;
                r_x   <= r_base_x;
                r_y   <= r_y + scale17;
            end else begin
                r_col <= r_col + COL_W'(1);
                r_x   <= r_x + scale17;
            end
        end
        if (i_cmd.emit) begin
            r_out_left   <= r_x;
            r_out_top    <= r_y;
            r_out_right  <= r_x + scale17;
            r_out_bottom <= r_y + scale17;
            r_out_last   <= o_status.rest_zero;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_quad_left   = r_out_left;
    assign o_quad_top    = r_out_top;
    assign o_quad_right  = r_out_right;
    assign o_quad_bottom = r_out_bottom;
    assign o_last_quad   = r_out_last;

    a_emit_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (o_status.cur_lit && o_status.out_free))
        else $error("quad emitted without lit pixel or free output slot");

    a_quad_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_out_right - r_out_left) == scale17
                         && (r_out_bottom - r_out_top) == scale17))
        else $error("quad side differs from scale");

    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && o_status.rest_zero) |=> (r_out_valid && r_out_last))
        else $error("final quad of character not marked");

endmodule

// File: src/bitmap_glyph_quad_generator.sv
`timescale 1ns / 1ps
// channel  | direction | handshake               | payload
// ---------+-----------+-------------------------+------------------------------------------
// in       | input     | i_in_valid / o_in_stall | char_code, string_start, origin_x/y
// out      | output    | o_out_valid / i_out_stall | quad_left/top/right/bottom, last_quad
// cfg      | input     | i_cfg_valid / o_cfg_ready | font_size (one register)
//
// a printable character is loaded and then scanned pixel by pixel, up to 35 glyph pixels,
// one cell per cycle while a lit pixel is not held by the output; the scan ends after the last lit pixel
// blank codes (space, cr, lf, tab) are loaded without a scan and emit no transaction
// a lit pixel holds the scan while the output register is full and stalled
// synchronous active-low reset: font size 16, cursor 0, output empty

module bitmap_glyph_quad_generator
    import bgqg_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [7:0]                 i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [7:0]                 i_char_code,
    input  logic                       i_string_start,
    input  logic signed [15:0]         i_origin_x,
    input  logic signed [15:0]         i_origin_y,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [COORD_W-1:0]  o_quad_left,
    output logic signed [COORD_W-1:0]  o_quad_top,
    output logic signed [COORD_W-1:0]  o_quad_right,
    output logic signed [COORD_W-1:0]  o_quad_bottom,
    output logic                       o_last_quad
);

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    bgqg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    bgqg_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_char_code    (i_char_code),
        .i_string_start (i_string_start),
        .i_origin_x     (i_origin_x),
        .i_origin_y     (i_origin_y),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_quad_left    (o_quad_left),
        .o_quad_top     (o_quad_top),
        .o_quad_right   (o_quad_right),
        .o_quad_bottom  (o_quad_bottom),
        .o_last_quad    (o_last_quad)
    );

endmodule
